[rtl/ebf_pkg.sv]
// ----------------------------------------------------------------------------
// ebf_pkg: shared types and constants of the ECG beat framer
// Word layouts, register indexes, phase codes, controller command and status.
// ----------------------------------------------------------------------------
`default_nettype none

package ebf_pkg;

  localparam int MAX_WINDOW_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int SAMPLE_W   = 12;
  localparam int TICK_W     = 32;
  localparam int PHASE_W    = 2;
  localparam int RATE_W     = 8;
  localparam int WLEN_W     = 5;
  localparam int POST_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int DIV_W      = 32;
  localparam int DVS_W      = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_LEN    = 2'd2;

  localparam logic [WLEN_W-1:0]   WINDOW_LEN_RST = 5'd10;
  localparam logic [SAMPLE_W-1:0] START_THR_RST  = 12'd2600;
  localparam logic [POST_W-1:0]   POST_LEN_RST   = 8'd128;

  localparam logic [PHASE_W-1:0] PH_PRE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_BEAT = 2'd1;
  localparam logic [PHASE_W-1:0] PH_POST = 2'd2;

  localparam logic [7:0] RUN_LIMIT = 8'd3;
  localparam logic [7:0] RUN_SAT   = 8'd255;
  localparam int MS_PER_S  = 1000;
  localparam int RATE_NUM  = 120;
  localparam int SECS_MAX  = 120;
  localparam int THR_DIV   = 5;
  localparam logic [RATE_W-1:0] RATE_SAT = 8'd255;

  // floor(x/1000) for 32-bit x as (x * SECS_RECIP) >> SECS_SHIFT
  localparam int          SECS_PROD_W = 61;
  localparam int          SECS_SHIFT  = 38;
  localparam logic [28:0] SECS_RECIP  = 29'd274877907;

  // floor(x/5) for 14-bit x as (x * THR_RECIP) >> THR_SHIFT
  localparam int          THR_PROD_W = 30;
  localparam int          THR_SHIFT  = 18;
  localparam logic [15:0] THR_RECIP  = 16'd52429;

  typedef enum logic [0:0] {
    DIV_AVG,
    DIV_RATE
  } div_sel_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [TICK_W-1:0]   tick_ms;
  } ebf_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smoothed;
    logic [PHASE_W-1:0]  phase;
    logic                beat_done;
    logic [RATE_W-1:0]   heart_rate;
    logic [TICK_W-1:0]   peak_time;
    logic                cycle_done;
  } ebf_out_t;

  typedef struct packed {
    logic     load;
    logic     sum_clr;
    logic     sum_step;
    logic     div_start;
    div_sel_e div_sel;
    logic     avg_take;
    logic     frame;
    logic     secs_load;
    logic     secs_take;
    logic     rate_take;
    logic     thr_take;
    logic     out_load;
  } ebf_cmd_t;

  typedef struct packed {
    logic full;
    logic sum_done;
    logic div_busy;
    logic div_done;
    logic beat_end;
    logic restart;
    logic cmax_nz;
    logic secs_direct;
    logic out_free;
  } ebf_sts_t;

endpackage

`default_nettype wire

[rtl/ebf_ram.sv]
// ----------------------------------------------------------------------------
// ebf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ebf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/ebf_div.sv]
// ----------------------------------------------------------------------------
// ebf_div: iterative restoring divider
// One quotient bit per cycle; done pulses when the quotient is final.
// ----------------------------------------------------------------------------
`default_nettype none

module ebf_div
  import ebf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic      [DIV_W-1:0] quo_o
);

  localparam int CntW = $clog2(DIV_W);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DIV_W-2:0], ge};
      rem_d = ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

[rtl/ebf_dp.sv]
// ----------------------------------------------------------------------------
// ebf_dp: datapath of the ECG beat framer
// Config registers, window RAM and sum, divider, phase state, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ebf_dp
  import ebf_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire ebf_in_t               in_data_i,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output ebf_out_t                   out_data_o,
  input  wire ebf_cmd_t              cmd_i,
  output ebf_sts_t                   sts_o
);

  localparam int IdxW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LenW = $clog2(MAX_WINDOW + 1);
  localparam int SumW = SAMPLE_BITS + IdxW;

  logic [WLEN_W-1:0]   win_len_q;
  logic [SAMPLE_W-1:0] start_thr_q;
  logic [POST_W-1:0]   post_len_q;

  logic [LenW-1:0]     len;
  logic [POST_W-1:0]   plen;

  logic [IdxW-1:0]     fill_q;
  logic                full_q;
  logic [LenW-1:0]     idx_nxt;

  logic [LenW-1:0]     cnt_q;
  logic                pend_q;
  logic [SumW-1:0]     acc_q;
  logic [SAMPLE_BITS-1:0] rdata;

  logic [PHASE_W-1:0]  phase_q;
  logic [7:0]          rc_q;
  logic [SAMPLE_W-1:0] thr_q;
  logic [SAMPLE_W-1:0] peak_q;
  logic [TICK_W-1:0]   pk_tick_q;
  logic [TICK_W-1:0]   last_tick_q;
  logic [SAMPLE_W-1:0] cmax_q;
  logic [RATE_W-1:0]   rate_q;
  logic [SAMPLE_W-1:0] avg_q;
  logic [TICK_W-1:0]   tick_q;
  logic [PHASE_W-1:0]  handled_q;
  logic                beat_done_q;
  logic                cycle_done_q;
  logic                out_valid_q;
  ebf_out_t            out_q;
  logic [TICK_W-1:0]   dt_q;
  logic [SAMPLE_W-1:0] thr_src_q;
  logic [DIV_W-1:0]    secs_q;

  logic [SAMPLE_W-1:0] cmax_n;
  logic                above;
  logic [7:0]          rc_inc;
  logic [7:0]          rc_n;
  logic [PHASE_W-1:0]  ph_n;
  logic [PHASE_W-1:0]  handled;
  logic [SAMPLE_W-1:0] peak_n;
  logic [TICK_W-1:0]   pk_tick_n;
  logic                beat_end;
  logic                restart;
  logic [TICK_W-1:0]   dt;

  logic [SECS_PROD_W-1:0] secs_prod;
  logic [THR_PROD_W-1:0]  thr_prod;
  logic [SAMPLE_W-1:0]    thr_new;

  logic             div_busy, div_done;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             secs_zero, secs_big;

  // effective lengths
  always_comb begin
    if (win_len_q == '0) begin
      len = LenW'(1);
    end else if (int'(win_len_q) > MAX_WINDOW) begin
      len = LenW'(MAX_WINDOW);
    end else begin
      len = LenW'(win_len_q);
    end
    plen    = (post_len_q == '0) ? POST_W'(1) : post_len_q;
    idx_nxt = LenW'(fill_q) + LenW'(1);
  end

  ebf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (fill_q),
    .wdata_i (SAMPLE_BITS'(in_data_i.sample)),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  // beat framing step
  always_comb begin
    cmax_n    = (avg_q > cmax_q) ? avg_q : cmax_q;
    above     = avg_q > thr_q;
    rc_inc    = rc_q + 8'd1;
    rc_n      = rc_q;
    ph_n      = phase_q;
    handled   = phase_q;
    peak_n    = peak_q;
    pk_tick_n = pk_tick_q;
    beat_end  = 1'b0;
    restart   = 1'b0;
    case (phase_q)
      PH_PRE: begin
        rc_n = above ? rc_inc : 8'd0;
        if (rc_n >= RUN_LIMIT) begin
          rc_n = 8'd0;
          ph_n = PH_BEAT;
        end
      end
      PH_BEAT: begin
        if (above) begin
          rc_n = 8'd0;
          if (avg_q > peak_q) begin
            peak_n    = avg_q;
            pk_tick_n = tick_q;
          end
        end else begin
          rc_n = rc_inc;
        end
        if (rc_n >= RUN_LIMIT) begin
          rc_n     = 8'd0;
          ph_n     = PH_POST;
          beat_end = 1'b1;
        end
      end
      default: begin
        handled = PH_POST;
        rc_n    = (rc_q < RUN_SAT) ? rc_inc : rc_q;
        if (rc_n >= plen) begin
          restart = 1'b1;
        end
      end
    endcase
    dt = pk_tick_n - last_tick_q;
  end

  // constant divisions by reciprocal multiplication
  always_comb begin
    secs_prod = SECS_PROD_W'(dt_q) * SECS_PROD_W'(SECS_RECIP);
    thr_prod  = THR_PROD_W'({thr_src_q, 2'b00}) * THR_PROD_W'(THR_RECIP);
    thr_new   = thr_prod[THR_PROD_W-1:THR_SHIFT];
  end

  // divider operands
  always_comb begin
    case (cmd_i.div_sel)
      DIV_AVG: begin
        div_dividend = DIV_W'(acc_q);
        div_divisor  = DVS_W'(len);
      end
      DIV_RATE: begin
        div_dividend = DIV_W'(RATE_NUM) + secs_q;
        div_divisor  = {secs_q[DVS_W-2:0], 1'b0};
      end
      default: begin
        div_dividend = DIV_W'(acc_q);
        div_divisor  = DVS_W'(len);
      end
    endcase
  end

  ebf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  assign secs_zero = secs_q == '0;
  assign secs_big  = secs_q > DIV_W'(SECS_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q    <= WINDOW_LEN_RST;
      start_thr_q  <= START_THR_RST;
      post_len_q   <= POST_LEN_RST;
      fill_q       <= '0;
      full_q       <= 1'b0;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      phase_q      <= PH_PRE;
      rc_q         <= '0;
      thr_q        <= START_THR_RST;
      peak_q       <= '0;
      pk_tick_q    <= '0;
      last_tick_q  <= '0;
      cmax_q       <= '0;
      rate_q       <= '0;
      handled_q    <= PH_PRE;
      beat_done_q  <= 1'b0;
      cycle_done_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WINDOW_LEN: win_len_q   <= cfg_data_i[WLEN_W-1:0];
          CFG_START_THR:  start_thr_q <= cfg_data_i[SAMPLE_W-1:0];
          CFG_POST_LEN:   post_len_q  <= cfg_data_i[POST_W-1:0];
          default: ;
        endcase
      end

      if (cmd_i.load) begin
        if (idx_nxt >= len) begin
          fill_q <= '0;
          full_q <= 1'b1;
        end else begin
          fill_q <= IdxW'(idx_nxt);
        end
      end

      if (cmd_i.sum_clr) begin
        cnt_q  <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.sum_step) begin
        pend_q <= cnt_q < len;
        if (cnt_q < len) begin
          cnt_q <= cnt_q + LenW'(1);
        end
      end

      if (cmd_i.frame) begin
        handled_q    <= handled;
        beat_done_q  <= beat_end;
        cycle_done_q <= restart;
        if (restart) begin
          fill_q    <= '0;
          full_q    <= 1'b0;
          phase_q   <= PH_PRE;
          rc_q      <= '0;
          peak_q    <= '0;
          pk_tick_q <= '0;
          rate_q    <= '0;
          cmax_q    <= '0;
          if (cmax_n == '0) begin
            thr_q <= start_thr_q;
          end
        end else begin
          phase_q   <= ph_n;
          rc_q      <= rc_n;
          peak_q    <= peak_n;
          pk_tick_q <= pk_tick_n;
          cmax_q    <= cmax_n;
          if (beat_end) begin
            last_tick_q <= pk_tick_n;
          end
        end
      end

      if (cmd_i.secs_take) begin
        if (secs_zero) begin
          rate_q <= RATE_SAT;
        end else if (secs_big) begin
          rate_q <= '0;
        end
      end
      if (cmd_i.rate_take) begin
        rate_q <= div_quo[RATE_W-1:0];
      end
      if (cmd_i.thr_take) begin
        thr_q <= thr_new;
      end

      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tick_q <= in_data_i.tick_ms;
    end
    if (cmd_i.sum_clr) begin
      acc_q <= '0;
    end else if (cmd_i.sum_step && pend_q) begin
      acc_q <= acc_q + SumW'(rdata);
    end
    if (cmd_i.avg_take) begin
      avg_q <= div_quo[SAMPLE_W-1:0];
    end
    if (cmd_i.frame) begin
      dt_q      <= dt;
      thr_src_q <= cmax_n;
    end
    if (cmd_i.secs_load) begin
      secs_q <= DIV_W'(secs_prod[SECS_PROD_W-1:SECS_SHIFT]);
    end
    if (cmd_i.out_load) begin
      out_q.smoothed   <= avg_q;
      out_q.phase      <= handled_q;
      out_q.beat_done  <= beat_done_q;
      out_q.heart_rate <= rate_q;
      out_q.peak_time  <= last_tick_q;
      out_q.cycle_done <= cycle_done_q;
    end
  end

  always_comb begin
    sts_o.full        = full_q;
    sts_o.sum_done    = (cnt_q >= len) && !pend_q;
    sts_o.div_busy    = div_busy;
    sts_o.div_done    = div_done;
    sts_o.beat_end    = beat_end;
    sts_o.restart     = restart;
    sts_o.cmax_nz     = cmax_n != '0;
    sts_o.secs_direct = secs_zero || secs_big;
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/ebf_ctrl.sv]
// ----------------------------------------------------------------------------
// ebf_ctrl: sequencing state machine of the ECG beat framer
// Steps each word through load and, once the window is full, window sum, divisions,
// framing and output.
`default_nettype none

module ebf_ctrl
  import ebf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire ebf_sts_t sts_i,
  output ebf_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_SUM   = 4'd2;
  localparam logic [3:0] S_AVG   = 4'd3;
  localparam logic [3:0] S_FRAME = 4'd4;
  localparam logic [3:0] S_SECS  = 4'd5;
  localparam logic [3:0] S_RATE  = 4'd6;
  localparam logic [3:0] S_THR   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_SDEC  = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_stall_o = state_q != S_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.full) begin
          cmd_o.sum_clr = 1'b1;
          state_d       = S_SUM;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.sum_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_AVG;
          state_d         = S_AVG;
        end
      end
      S_AVG: begin
        if (sts_i.div_done) begin
          cmd_o.avg_take = 1'b1;
          state_d        = S_FRAME;
        end
      end
      S_FRAME: begin
        cmd_o.frame = 1'b1;
        if (sts_i.beat_end) begin
          state_d = S_SECS;
        end else if (sts_i.restart && sts_i.cmax_nz) begin
          state_d = S_THR;
        end else begin
          state_d = S_OUT;
        end
      end
      S_SECS: begin
        cmd_o.secs_load = 1'b1;
        state_d         = S_SDEC;
      end
      S_SDEC: begin
        if (sts_i.secs_direct) begin
          cmd_o.secs_take = 1'b1;
          state_d         = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_RATE;
          state_d         = S_RATE;
        end
      end
      S_RATE: begin
        if (sts_i.div_done) begin
          cmd_o.rate_take = 1'b1;
          state_d         = S_OUT;
        end
      end
      S_THR: begin
        cmd_o.thr_take = 1'b1;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.div_busy)
    else $error("divider started while busy");

  a_div_busy_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_busy |-> (state_q == S_AVG || state_q == S_RATE))
    else $error("divider running outside a wait state");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_AVG || state_q == S_RATE))
    else $error("divider result arrived outside a wait state");

  a_frame_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FRAME |-> !(sts_i.beat_end && sts_i.restart))
    else $error("beat end and restart in one word");
`endif

endmodule

`default_nettype wire

[rtl/ecg_beat_framer.sv]
// ----------------------------------------------------------------------------
// ecg_beat_framer: moving-average beat detector and framer for ECG samples
// Each word is written to the window RAM; once the window is full it is summed,
// averaged by the divider and framed; a beat end adds a rate step, a restart with a
// nonzero max a threshold update. Input stalls until the word's result is loaded.
// Reset: async low clears control, config, phase and rate state; window RAM is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module ecg_beat_framer
  import ebf_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire ebf_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output ebf_out_t                   out_data_o
);

  ebf_cmd_t cmd;
  ebf_sts_t sts;

  ebf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ebf_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

[dv/ecg_beat_framer_tb.sv]
// ----------------------------------------------------------------------------
// ecg_beat_framer_tb: self-checking bench for the ECG beat framer
// A scoreboard class mirrors the window average, the beat framing phases,
// the heart rate and the cycle restart for every accepted sample word, and
// compares each result word field by field. A directed opening covers field
// extremes, a window length change while filling, out-of-range window and
// post lengths, a zero-second beat interval and a wrapped tick difference.
// Random phases then send beat-shaped waveforms with noise under several
// register settings while both handshake sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module ecg_beat_framer_tb;
  import ebf_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int SETTLE       = 200;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 40;
  localparam int SHOW_MAX     = 10;

  class frame_tracker;
    logic [WLEN_W-1:0]   win_len;
    logic [SAMPLE_W-1:0] start_thr;
    logic [POST_W-1:0]   post_len;

    logic [SAMPLE_W-1:0] store [MAX_WINDOW_DEF];
    bit                  written [MAX_WINDOW_DEF];
    int unsigned         fill;
    bit                  full;
    logic [PHASE_W-1:0]  ph;
    logic [7:0]          run;
    logic [SAMPLE_W-1:0] thr;
    logic [SAMPLE_W-1:0] peak_val;
    logic [TICK_W-1:0]   peak_tk;
    logic [TICK_W-1:0]   last_peak;
    logic [SAMPLE_W-1:0] cmax;
    logic [RATE_W-1:0]   rate;

    ebf_out_t            pending [$];
    int unsigned         faults;

    function new();
      win_len   = WINDOW_LEN_RST;
      start_thr = START_THR_RST;
      post_len  = POST_LEN_RST;
      for (int i = 0; i < MAX_WINDOW_DEF; i++) begin
        store[i]   = '0;
        written[i] = 1'b0;
      end
      fill      = 0;
      full      = 1'b0;
      ph        = PH_PRE;
      run       = '0;
      thr       = START_THR_RST;
      peak_val  = '0;
      peak_tk   = '0;
      last_peak = '0;
      cmax      = '0;
      rate      = '0;
      faults    = 0;
    endfunction

    function int unsigned eff_span(logic [WLEN_W-1:0] l);
      if (l == 0) return 1;
      if (l > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
      return l;
    endfunction

    function int unsigned span();
      return eff_span(win_len);
    endfunction

    // longest window that reads only written entries
    function int unsigned safe_span();
      if (!full) return MAX_WINDOW_DEF;
      for (int i = 0; i < MAX_WINDOW_DEF; i++) begin
        if (!written[i]) return i;
      end
      return MAX_WINDOW_DEF;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_WINDOW_LEN: win_len   = v[WLEN_W-1:0];
        CFG_START_THR:  start_thr = v[SAMPLE_W-1:0];
        CFG_POST_LEN:   post_len  = v[POST_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [RATE_W-1:0] bpm_from(logic [TICK_W-1:0] dt);
      longint unsigned secs;
      secs = dt / MS_PER_S;
      if (secs == 0) return RATE_SAT;
      return RATE_W'((RATE_NUM + secs) / (2 * secs));
    endfunction

    function void absorb_sample(ebf_in_t w);
      int unsigned        len;
      int unsigned        idx;
      int unsigned        acc;
      int unsigned        avg;
      logic [7:0]         plen;
      logic [PHASE_W-1:0] handled;
      bit                 bdone;
      bit                 cdone;
      ebf_out_t           f;
      len  = span();
      idx  = fill % MAX_WINDOW_DEF;
      plen = (post_len == 0) ? 8'd1 : post_len;
      store[idx]   = w.sample;
      written[idx] = 1'b1;
      if (idx + 1 >= len) begin
        fill = 0;
        full = 1'b1;
      end else begin
        fill = idx + 1;
      end
      if (!full) return;

      acc = 0;
      for (int i = 0; i < len; i++) acc += store[i];
      avg = acc / len;
      if (avg > cmax) cmax = SAMPLE_W'(avg);

      handled = ph;
      bdone   = 1'b0;
      cdone   = 1'b0;
      case (ph)
        PH_PRE: begin
          if (avg <= thr) run = '0;
          else run = run + 8'd1;
          if (run >= RUN_LIMIT) begin
            run = '0;
            ph  = PH_BEAT;
          end
        end
        PH_BEAT: begin
          if (avg > thr) begin
            run = '0;
            if (avg > peak_val) begin
              peak_val = SAMPLE_W'(avg);
              peak_tk  = w.tick_ms;
            end
          end else begin
            run = run + 8'd1;
          end
          if (run >= RUN_LIMIT) begin
            run       = '0;
            rate      = bpm_from(peak_tk - last_peak);
            last_peak = peak_tk;
            ph        = PH_POST;
            bdone     = 1'b1;
          end
        end
        default: begin
          handled = PH_POST;
          if (run < RUN_SAT) run = run + 8'd1;
          if (run >= plen) begin
            cdone    = 1'b1;
            thr      = (cmax != 0) ? SAMPLE_W'((4 * int'(cmax)) / THR_DIV) : start_thr;
            fill     = 0;
            full     = 1'b0;
            ph       = PH_PRE;
            run      = '0;
            peak_val = '0;
            peak_tk  = '0;
            rate     = '0;
            cmax     = '0;
          end
        end
      endcase

      f.smoothed   = SAMPLE_W'(avg);
      f.phase      = handled;
      f.beat_done  = bdone;
      f.heart_rate = rate;
      f.peak_time  = last_peak;
      f.cycle_done = cdone;
      pending.push_back(f);
    endfunction

    function void compare_frame(ebf_out_t got);
      ebf_out_t want;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= SHOW_MAX) $display("unexpected result word %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.smoothed !== want.smoothed || got.phase !== want.phase ||
          got.beat_done !== want.beat_done || got.heart_rate !== want.heart_rate ||
          got.peak_time !== want.peak_time || got.cycle_done !== want.cycle_done) begin
        faults++;
        if (faults <= SHOW_MAX) begin
          $display("mismatch exp avg=%0d ph=%0d bd=%0b hr=%0d pt=%0h cd=%0b",
                   want.smoothed, want.phase, want.beat_done, want.heart_rate,
                   want.peak_time, want.cycle_done);
          $display("         got avg=%0d ph=%0d bd=%0b hr=%0d pt=%0h cd=%0b",
                   got.smoothed, got.phase, got.beat_done, got.heart_rate,
                   got.peak_time, got.cycle_done);
        end
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  ebf_in_t               in_data_i   = '0;
  logic                  out_stall_i = 1'b0;
  wire logic             in_stall_o;
  wire logic             out_valid_o;
  ebf_out_t              out_data_o;

  frame_tracker tracker = new();

  bit                 calm = 1'b0;
  logic [TICK_W-1:0]  tick_now = '0;
  int unsigned        seg_left = 0;
  bit                 seg_high = 1'b0;
  int unsigned        level = 0;

  ecg_beat_framer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < 38);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.compare_frame(out_data_o);
    out_stall_i <= idle_roll();
  end

  // beat-shaped waveform: low stretches, high bursts, some short bursts and noise
  function automatic ebf_in_t next_word();
    ebf_in_t     w;
    int unsigned roll;
    if (seg_left == 0) begin
      seg_high = ($urandom_range(99) < 45);
      if (seg_high) begin
        level    = $urandom_range(4095, 3600);
        seg_left = ($urandom_range(99) < 20) ? $urandom_range(2, 1)
                                             : tracker.span() + $urandom_range(8, 3);
      end else begin
        level    = $urandom_range(900, 0);
        seg_left = $urandom_range(tracker.span() + 8, 2);
      end
    end
    seg_left--;
    roll = $urandom_range(99);
    if (roll < 10) w.sample = SAMPLE_W'($urandom);
    else if (seg_high) w.sample = SAMPLE_W'(level - $urandom_range(150, 0));
    else w.sample = SAMPLE_W'($urandom_range(level, 0));
    roll = $urandom_range(99);
    if (roll < 70) tick_now = tick_now + $urandom_range(600, 100);
    else if (roll < 85) tick_now = tick_now + $urandom_range(3, 0);
    else if (roll < 95) tick_now = tick_now + $urandom_range(5000, 1000);
    else tick_now = $urandom;
    w.tick_ms = tick_now;
    return w;
  endfunction

  task automatic send_word(input ebf_in_t w);
    while (idle_roll()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.absorb_sample(w);
  endtask

  task automatic send(input logic [SAMPLE_W-1:0] s, input logic [TICK_W-1:0] t);
    ebf_in_t w;
    w.sample  = s;
    w.tick_ms = t;
    send_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    tracker.set_reg(idx, v);
  endtask

  task automatic load_regs(input logic [WLEN_W-1:0] len, input logic [SAMPLE_W-1:0] thr,
                           input logic [POST_W-1:0] post);
    write_reg(CFG_WINDOW_LEN, CFG_DATA_W'(len));
    write_reg(CFG_START_THR, CFG_DATA_W'(thr));
    write_reg(CFG_POST_LEN, CFG_DATA_W'(post));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [WLEN_W-1:0]   lens  [PHASES];
    logic [SAMPLE_W-1:0] thrs  [PHASES];
    logic [POST_W-1:0]   posts [PHASES];
    logic [WLEN_W-1:0]   want_len;
    int unsigned         extra;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shrink the window while it fills
    load_regs(5'd8, 12'd0, 8'd0);
    send(12'd0, 32'd0);
    send(12'hFFF, 32'hFFFF_FFFF);
    send(12'hAAA, 32'h5555_5555);
    send(12'h555, 32'hAAAA_AAAA);
    send(12'hFFF, 32'd1);
    drain();
    load_regs(5'd3, 12'd0, 8'd0);
    send(12'd1234, 32'd2);
    drain();

    // zero window length, zero post length, zero-second and wrapped beat intervals
    load_regs(5'd0, 12'hFFF, 8'd0);
    send(12'hFFF, 32'd0);
    send(12'hFFF, 32'hFFFF_FFFF);
    send(12'hFFF, 32'd3);
    send(12'hFFF, 32'd10);
    send(12'd0, 32'd20);
    send(12'd0, 32'd25);
    send(12'd0, 32'd30);
    send(12'd0, 32'd31);
    send(12'hFFF, 32'd40);
    send(12'hFFF, 32'd41);
    send(12'hFFF, 32'd42);
    send(12'hFFF, 32'd5);
    send(12'd0, 32'd50);
    send(12'd0, 32'd51);
    send(12'd0, 32'd52);
    tick_now = 32'd2000;

    for (int p = 0; p < PHASES; p++) begin
      lens[p]  = WLEN_W'($urandom_range(16, 1));
      thrs[p]  = SAMPLE_W'($urandom_range(4095, 0));
      posts[p] = POST_W'($urandom_range(24, 1));
    end
    lens[0] = 5'd16;  lens[1] = 5'd31;  lens[2] = 5'd1;  lens[3] = 5'd0;  lens[4] = 5'd20;
    posts[0] = 8'd4;  posts[1] = 8'd1;  posts[2] = 8'd0;
    posts[PHASES-2] = 8'd128;  posts[PHASES-1] = 8'd255;
    thrs[0] = 12'd0;  thrs[1] = 12'hFFF;

    for (int p = 0; p < PHASES; p++) begin
      want_len = lens[p];
      extra    = 0;
      while (tracker.safe_span() < tracker.eff_span(want_len) && extra < 80) begin
        send_word(next_word());
        extra++;
      end
      if (tracker.safe_span() < tracker.eff_span(want_len))
        want_len = WLEN_W'(tracker.safe_span());
      drain();
      calm <= (p == 4 || p == 5);
      load_regs(want_len, thrs[p], posts[p]);
      repeat (PHASE_ITEMS) send_word(next_word());
    end
    drain();

    if (tracker.faults == 0 && tracker.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/ebf_pkg.sv
rtl/ebf_ram.sv
rtl/ebf_div.sv
rtl/ebf_dp.sv
rtl/ebf_ctrl.sv
rtl/ecg_beat_framer.sv
dv/ecg_beat_framer_tb.sv
